>>> src/text_console_cursor_controller_assert.svh
// Assertion macros shared by the console cursor controller.
// Both expect clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define TTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cursor controller assertion failed");

// Next-cycle implication
`define TTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cursor controller assertion failed");

`endif

>>> src/ttc_pkg.sv
package ttc_pkg;

  // Parameter defaults
  localparam int unsigned MAX_COLUMNS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 128;
  localparam int unsigned TAB_SPACES_DEF  = 4;

  // Results kept per input byte; later ones are dropped
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int unsigned APB_AW = 5;

  // Control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Input commands
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // Register reset values
  localparam logic [8:0]  TEXT_COLUMNS_RST   = 9'd80;
  localparam logic [7:0]  TEXT_ROWS_RST      = 8'd25;
  localparam logic [7:0]  PROMPT_COLUMN_RST  = 8'd0;
  localparam logic [23:0] FOREGROUND_RGB_RST = 24'hFFFFFF;
  localparam logic [23:0] BACKGROUND_RGB_RST = 24'h000000;

  typedef enum logic [2:0] {
    REG_TEXT_COLUMNS   = 3'd0,
    REG_TEXT_ROWS      = 3'd1,
    REG_PROMPT_COLUMN  = 3'd2,
    REG_FOREGROUND_RGB = 3'd3,
    REG_BACKGROUND_RGB = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_DRAW
  } op_e;

  // Effective geometry and colours
  typedef struct packed {
    logic [7:0]  cols_m1;
    logic [6:0]  rows_m1;
    logic [7:0]  prompt;
    logic [23:0] fg;
    logic [23:0] bg;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [23:0] text_rgb;
    logic [23:0] fill_rgb;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
  } cursor_t;

endpackage

>>> src/ttc_in_if.sv
interface ttc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;

  modport source (output valid, output cmd, output char_code, input ready);
  modport sink (input valid, input cmd, input char_code, output ready);
endinterface

>>> src/ttc_out_if.sv
interface ttc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  cell_column;
  logic [6:0]  cell_row;
  logic [7:0]  glyph_code;
  logic [23:0] text_rgb;
  logic [23:0] fill_rgb;
  logic        last;

  modport source (
    output valid, output action, output cell_column, output cell_row,
    output glyph_code, output text_rgb, output fill_rgb, output last,
    input ready
  );
  modport sink (
    input valid, input action, input cell_column, input cell_row,
    input glyph_code, input text_rgb, input fill_rgb, input last,
    output ready
  );
endinterface

>>> src/ttc_cfg_regs.sv
module ttc_cfg_regs #(
  parameter int unsigned MAX_COLUMNS = ttc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = ttc_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttc_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ttc_pkg::cfg_t                cfg_o
);
  import ttc_pkg::*;

  localparam int unsigned ColLim = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int unsigned RowLim = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam logic [8:0]  ColLimW = 9'(ColLim);
  localparam logic [7:0]  RowLimW = 8'(RowLim);

  logic [8:0]  text_columns_q;
  logic [7:0]  text_rows_q;
  logic [7:0]  prompt_column_q;
  logic [23:0] foreground_rgb_q;
  logic [23:0] background_rgb_q;
  logic        wr_en;
  logic [2:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[APB_AW-1:2];

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_columns_q   <= TEXT_COLUMNS_RST;
      text_rows_q      <= TEXT_ROWS_RST;
      prompt_column_q  <= PROMPT_COLUMN_RST;
      foreground_rgb_q <= FOREGROUND_RGB_RST;
      background_rgb_q <= BACKGROUND_RGB_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TEXT_COLUMNS:   text_columns_q   <= pwdata[8:0];
        REG_TEXT_ROWS:      text_rows_q      <= pwdata[7:0];
        REG_PROMPT_COLUMN:  prompt_column_q  <= pwdata[7:0];
        REG_FOREGROUND_RGB: foreground_rgb_q <= pwdata[23:0];
        REG_BACKGROUND_RGB: background_rgb_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_TEXT_COLUMNS:   prdata = {23'd0, text_columns_q};
      REG_TEXT_ROWS:      prdata = {24'd0, text_rows_q};
      REG_PROMPT_COLUMN:  prdata = {24'd0, prompt_column_q};
      REG_FOREGROUND_RGB: prdata = {8'd0, foreground_rgb_q};
      REG_BACKGROUND_RGB: prdata = {8'd0, background_rgb_q};
      default:            prdata = '0;
    endcase
  end

  // Saturate geometry: zero counts as one, large values clip to the limit
  always_comb begin
    if (text_columns_q == '0) begin
      cfg_o.cols_m1 = '0;
    end else if (text_columns_q > ColLimW) begin
      cfg_o.cols_m1 = 8'(ColLimW - 9'd1);
    end else begin
      cfg_o.cols_m1 = 8'(text_columns_q - 9'd1);
    end
    if (text_rows_q == '0) begin
      cfg_o.rows_m1 = '0;
    end else if (text_rows_q > RowLimW) begin
      cfg_o.rows_m1 = 7'(RowLimW - 8'd1);
    end else begin
      cfg_o.rows_m1 = 7'(text_rows_q - 8'd1);
    end
    cfg_o.prompt = prompt_column_q;
    cfg_o.fg     = foreground_rgb_q;
    cfg_o.bg     = background_rgb_q;
  end

endmodule

>>> src/ttc_step.sv
module ttc_step #(
  parameter int unsigned TAB_SPACES = ttc_pkg::TAB_SPACES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttc_pkg::cfg_t    cfg_i,
  ttc_in_if.sink           in_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ttc_pkg::res_t    res_o,
  output ttc_pkg::cursor_t cursor_o,
  output logic             fire_o
);
  import ttc_pkg::*;

  localparam int unsigned   RemW   = $clog2(TAB_SPACES + 1);
  localparam logic [RemW-1:0] RemTab = RemW'(TAB_SPACES);
  localparam logic [RemW-1:0] RemOne = RemW'(1);
  localparam logic [RES_CNT_W-1:0] CntMax  = RES_CNT_W'(MAX_RESULTS);
  localparam logic [RES_CNT_W-1:0] CntLast = RES_CNT_W'(MAX_RESULTS - 1);

  // Item register
  logic                 item_vld_q, item_vld_d;
  op_e                  op_q, op_d;
  logic [7:0]           glyph_q, glyph_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic                 scroll_q, scroll_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  // Cursor
  logic [7:0]           col_q, col_d;
  logic [6:0]           row_q, row_d;

  logic [7:0]      col_c;
  logic [6:0]      row_c;
  logic            emit_want, emit, item_end, fire, accept;
  action_e         st_act;
  logic [7:0]      st_col, st_glyph;
  logic [6:0]      st_row;
  logic [23:0]     st_fg, st_bg;
  logic [7:0]      col_nx;
  logic [6:0]      row_nx;
  logic [RemW-1:0] rem_nx;
  logic            scroll_nx;
  op_e             new_op;
  logic [7:0]      new_glyph;
  logic [RemW-1:0] new_rem;

  // Pull the cursor back into the grid
  assign col_c = (col_q > cfg_i.cols_m1) ? cfg_i.cols_m1 : col_q;
  assign row_c = (row_q > cfg_i.rows_m1) ? cfg_i.rows_m1 : row_q;

  // One step of the current item: at most one result
  always_comb begin
    emit_want = 1'b0;
    item_end  = 1'b1;
    st_act    = ACT_DRAW;
    st_col    = col_c;
    st_row    = row_c;
    st_glyph  = glyph_q;
    st_fg     = cfg_i.fg;
    st_bg     = cfg_i.bg;
    col_nx    = col_c;
    row_nx    = row_c;
    rem_nx    = rem_q;
    scroll_nx = 1'b0;
    unique case (op_q)
      OP_INIT: begin
        emit_want = 1'b1;
        st_act    = ACT_CLEAR;
        st_col    = '0;
        st_row    = '0;
        st_glyph  = '0;
        st_fg     = '0;
        st_bg     = '0;
        col_nx    = '0;
        row_nx    = '0;
      end
      OP_NEWLINE: begin
        col_nx = '0;
        if (row_c == cfg_i.rows_m1) begin
          emit_want = 1'b1;
          st_act    = ACT_SCROLL;
          st_col    = '0;
          st_row    = '0;
          st_glyph  = CH_SPACE;
          st_fg     = cfg_i.bg;
        end else begin
          row_nx = row_c + 7'd1;
        end
      end
      OP_RETURN: begin
        col_nx = '0;
      end
      OP_BACKSPACE: begin
        if (col_c > cfg_i.prompt) begin
          emit_want = 1'b1;
          col_nx    = col_c - 8'd1;
          st_col    = col_c - 8'd1;
          st_glyph  = CH_SPACE;
        end
      end
      OP_DRAW: begin
        if (scroll_q) begin
          // Scroll owed by the previous wrap
          emit_want = 1'b1;
          st_act    = ACT_SCROLL;
          st_col    = '0;
          st_row    = '0;
          st_glyph  = CH_SPACE;
          st_fg     = cfg_i.bg;
          item_end  = (rem_q == '0);
        end else begin
          emit_want = 1'b1;
          rem_nx    = rem_q - RemOne;
          if (col_c == cfg_i.cols_m1) begin
            col_nx = '0;
            if (row_c == cfg_i.rows_m1) begin
              scroll_nx = 1'b1;
            end else begin
              row_nx = row_c + 7'd1;
            end
          end else begin
            col_nx = col_c + 8'd1;
          end
          item_end = (rem_q == RemOne) && !scroll_nx;
        end
      end
      default: ;
    endcase
  end

  // Drop results past the per-item limit; the last kept one is marked last
  assign emit   = emit_want && (cnt_q < CntMax);
  assign fire   = item_vld_q && (!emit || res_ready_i);
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !item_vld_q || (fire && item_end);

  assign res_valid_o    = item_vld_q && emit;
  assign res_o.action   = st_act;
  assign res_o.col      = st_col;
  assign res_o.row      = st_row;
  assign res_o.glyph    = st_glyph;
  assign res_o.text_rgb = st_fg;
  assign res_o.fill_rgb = st_bg;
  assign res_o.last     = item_end || (cnt_q == CntLast);

  assign cursor_o.col = col_q;
  assign cursor_o.row = row_q;
  assign fire_o       = fire;

  // Classify the incoming byte
  always_comb begin
    new_op    = OP_DRAW;
    new_glyph = in_i.char_code;
    new_rem   = RemOne;
    if (in_i.cmd == CMD_INIT) begin
      new_op = OP_INIT;
    end else begin
      case (in_i.char_code)
        CH_NEWLINE:   new_op = OP_NEWLINE;
        CH_RETURN:    new_op = OP_RETURN;
        CH_BACKSPACE: new_op = OP_BACKSPACE;
        CH_TAB: begin
          new_glyph = CH_SPACE;
          new_rem   = RemTab;
        end
        default: ;
      endcase
    end
  end

  // Advance the item and cursor, load the next transfer
  always_comb begin
    item_vld_d = item_vld_q;
    op_d       = op_q;
    glyph_d    = glyph_q;
    rem_d      = rem_q;
    scroll_d   = scroll_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    if (fire) begin
      col_d    = col_nx;
      row_d    = row_nx;
      rem_d    = rem_nx;
      scroll_d = scroll_nx;
      if (emit) begin
        cnt_d = cnt_q + RES_CNT_W'(1);
      end
    end
    if (!item_vld_q || (fire && item_end)) begin
      item_vld_d = accept;
      if (accept) begin
        op_d     = new_op;
        glyph_d  = new_glyph;
        rem_d    = new_rem;
        scroll_d = 1'b0;
        cnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      rem_q      <= '0;
      scroll_q   <= 1'b0;
      cnt_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      rem_q      <= rem_d;
      scroll_q   <= scroll_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    glyph_q <= glyph_d;
  end

endmodule

>>> src/ttc_out_reg.sv
module ttc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  ttc_pkg::res_t res_i,
  ttc_out_if.source     out_o
);
  import ttc_pkg::*;

  logic vld_q;
  res_t res_q;

  // Refill whenever the held result leaves or the slot is empty
  assign res_ready_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_ready_o) begin
      vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.action      = res_q.action;
  assign out_o.cell_column = res_q.col;
  assign out_o.cell_row    = res_q.row;
  assign out_o.glyph_code  = res_q.glyph;
  assign out_o.text_rgb    = res_q.text_rgb;
  assign out_o.fill_rgb    = res_q.fill_rgb;
  assign out_o.last        = res_q.last;

endmodule

>>> src/text_console_cursor_controller.sv
// Console cursor controller: takes a byte or an init command per input transfer and issues
// cell commands (draw glyph, scroll up, clear) while tracking the cursor. The step unit
// produces at most one result per clock, stalling while the output register (which holds
// one) is full and not drained. Most bytes and newline, return and backspace give at most one
// result; a drawn character that wraps on the bottom row adds a scroll, and a tab gives
// TAB_SPACES draws plus a scroll per bottom-row wrap. The next item is taken in the same cycle
// that the current one finishes, and results past eight per item are dropped while the cursor
// still moves. Write the configuration registers only while no item is in flight.
`include "text_console_cursor_controller_assert.svh"

module text_console_cursor_controller #(
  parameter int unsigned MAX_COLUMNS = ttc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = ttc_pkg::MAX_ROWS_DEF,
  parameter int unsigned TAB_SPACES  = ttc_pkg::TAB_SPACES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  ttc_in_if.sink                     in_i,
  ttc_out_if.source                  out_o
);
  import ttc_pkg::*;

  cfg_t    cfg;
  res_t    res;
  cursor_t cursor;
  logic    res_valid;
  logic    res_ready;
  logic    step_fire;

  ttc_cfg_regs #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ttc_step #(
    .TAB_SPACES (TAB_SPACES)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .cursor_o    (cursor),
    .fire_o      (step_fire)
  );

  ttc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );

  // A clear carries all-zero fields and ends its item
  `TTC_ASSERT_IMP(a_clear_blank, out_o.valid && out_o.action == ACT_CLEAR, out_o.cell_column == '0 && out_o.cell_row == '0 && out_o.glyph_code == '0 && out_o.text_rgb == '0 && out_o.fill_rgb == '0 && out_o.last)
  // A scroll brings in a blank row in the background colour
  `TTC_ASSERT_IMP(a_scroll_blank, out_o.valid && out_o.action == ACT_SCROLL, out_o.cell_column == '0 && out_o.cell_row == '0 && out_o.glyph_code == CH_SPACE && out_o.text_rgb == out_o.fill_rgb)
  // A step leaves the cursor inside the grid
  `TTC_ASSERT_NEXT(a_cursor_in_grid, step_fire && !(psel && penable && pwrite), cursor.col <= cfg.cols_m1 && cursor.row <= cfg.rows_m1)

endmodule

>>> tb/text_console_cursor_controller_test.sv
`timescale 1ns / 100ps

module text_console_cursor_controller_test;
  import ttc_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } console_byte_t;

  // Clock, reset and APB signals
  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Channel drive registers
  logic        in_valid_q  = 1'b0;
  logic        in_cmd_q    = 1'b0;
  logic [7:0]  in_char_q   = '0;
  logic        out_ready_q = 1'b0;

  ttc_in_if  in_if ();
  ttc_out_if out_if ();

  assign in_if.valid     = in_valid_q;
  assign in_if.cmd       = in_cmd_q;
  assign in_if.char_code = in_char_q;
  assign out_if.ready    = out_ready_q;

  text_console_cursor_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Bytes waiting to be sent, cell commands waiting to come out
  console_byte_t byte_q[$];
  res_t          cell_cmd_q[$];
  console_byte_t next_byte;
  res_t          want;

  bit failed  = 1'b0;
  bit no_idle = 1'b0;
  bit in_taken = 1'b0;
  int in_gap  = 0;
  int out_gap = 0;

  // Shadow registers and cursor of the console
  logic [8:0]  cfg_columns = TEXT_COLUMNS_RST;
  logic [7:0]  cfg_rows    = TEXT_ROWS_RST;
  logic [7:0]  cfg_prompt  = PROMPT_COLUMN_RST;
  logic [23:0] cfg_fg      = FOREGROUND_RGB_RST;
  logic [23:0] cfg_bg      = BACKGROUND_RGB_RST;
  int cur_col = 0;
  int cur_row = 0;
  int grid_cols;
  int grid_rows;
  res_t cell_batch[MAX_RESULTS];
  int   n_batch;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_cell(input action_e act, input int col, input int row,
                           input logic [7:0] glyph, input logic [23:0] fg,
                           input logic [23:0] bg);
    if (n_batch < MAX_RESULTS) begin
      cell_batch[n_batch].action   = act;
      cell_batch[n_batch].col      = col[7:0];
      cell_batch[n_batch].row      = row[6:0];
      cell_batch[n_batch].glyph    = glyph;
      cell_batch[n_batch].text_rgb = fg;
      cell_batch[n_batch].fill_rgb = bg;
      cell_batch[n_batch].last     = 1'b0;
      n_batch++;
    end
  endtask

  task automatic next_row();
    cur_row++;
    if (cur_row >= grid_rows) begin
      push_cell(ACT_SCROLL, 0, 0, CH_SPACE, cfg_bg, cfg_bg);
      cur_row = grid_rows - 1;
    end
  endtask

  task automatic draw_advance(input logic [7:0] glyph);
    push_cell(ACT_DRAW, cur_col, cur_row, glyph, cfg_fg, cfg_bg);
    cur_col++;
    if (cur_col >= grid_cols) begin
      cur_col = 0;
      next_row();
    end
  endtask

  // Work out the cell commands one byte or init causes
  task automatic console_step(input logic cmd, input logic [7:0] ch);
    int i;
    n_batch   = 0;
    grid_cols = (cfg_columns == 0) ? 1
              : ((cfg_columns > 256) ? 256 : int'(cfg_columns));
    grid_rows = (cfg_rows == 0) ? 1 : ((cfg_rows > 128) ? 128 : int'(cfg_rows));
    if (cmd == CMD_INIT) begin
      cur_col = 0;
      cur_row = 0;
      push_cell(ACT_CLEAR, 0, 0, 8'd0, 24'd0, 24'd0);
    end else begin
      if (cur_col >= grid_cols) cur_col = grid_cols - 1;
      if (cur_row >= grid_rows) cur_row = grid_rows - 1;
      case (ch)
        CH_NEWLINE: begin
          cur_col = 0;
          next_row();
        end
        CH_TAB: begin
          for (i = 0; i < TAB_SPACES_DEF; i++) draw_advance(CH_SPACE);
        end
        CH_RETURN: begin
          cur_col = 0;
        end
        CH_BACKSPACE: begin
          if (cur_col > int'(cfg_prompt)) begin
            cur_col--;
            push_cell(ACT_DRAW, cur_col, cur_row, CH_SPACE, cfg_fg, cfg_bg);
          end
        end
        default: draw_advance(ch);
      endcase
    end
    if (n_batch > 0) cell_batch[n_batch-1].last = 1'b1;
    for (i = 0; i < n_batch; i++) cell_cmd_q.push_back(cell_batch[i]);
  endtask

  // Drive the byte channel from the queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_q || in_taken) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_q <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_byte  = byte_q.pop_front();
          in_cmd_q   <= next_byte.cmd;
          in_char_q  <= next_byte.ch;
          in_valid_q <= 1'b1;
          in_gap     <= pick_gap();
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // Stall the command channel at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_ready_q <= 1'b0;
        out_gap     <= out_gap - 1;
      end else begin
        out_ready_q <= 1'b1;
        out_gap     <= pick_gap();
      end
    end
  end

  // Predict on each byte transfer, check each command transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) console_step(in_if.cmd, in_if.char_code);
      if (out_if.valid && out_if.ready) begin
        if (cell_cmd_q.size() == 0) begin
          $error("unexpected cell command: action %0d", out_if.action);
          failed = 1'b1;
        end else begin
          want = cell_cmd_q.pop_front();
          if (out_if.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, out_if.action);
            failed = 1'b1;
          end
          if (out_if.cell_column !== want.col) begin
            $error("cell_column: expected %0d, actual %0d", want.col, out_if.cell_column);
            failed = 1'b1;
          end
          if (out_if.cell_row !== want.row) begin
            $error("cell_row: expected %0d, actual %0d", want.row, out_if.cell_row);
            failed = 1'b1;
          end
          if (out_if.glyph_code !== want.glyph) begin
            $error("glyph_code: expected %0d, actual %0d", want.glyph, out_if.glyph_code);
            failed = 1'b1;
          end
          if (out_if.text_rgb !== want.text_rgb) begin
            $error("text_rgb: expected %h, actual %h", want.text_rgb, out_if.text_rgb);
            failed = 1'b1;
          end
          if (out_if.fill_rgb !== want.fill_rgb) begin
            $error("fill_rgb: expected %h, actual %h", want.fill_rgb, out_if.fill_rgb);
            failed = 1'b1;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_if.last);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic send(input logic cmd, input logic [7:0] ch);
    console_byte_t b;
    b.cmd = cmd;
    b.ch  = ch;
    byte_q.push_back(b);
  endtask

  // Hold off until every byte is sent and every command is out, then let the
  // step unit finish any silent byte
  task automatic settle();
    do @(negedge clk_i);
    while (byte_q.size() > 0 || in_valid_q || cell_cmd_q.size() > 0);
    repeat (20) @(negedge clk_i);
  endtask

  // Write one register through a setup and an access phase
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    case (idx)
      REG_TEXT_COLUMNS:   cfg_columns = value[8:0];
      REG_TEXT_ROWS:      cfg_rows    = value[7:0];
      REG_PROMPT_COLUMN:  cfg_prompt  = value[7:0];
      REG_FOREGROUND_RGB: cfg_fg      = value[23:0];
      REG_BACKGROUND_RGB: cfg_bg      = value[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_screen(input logic [8:0] cols, input logic [7:0] rows,
                            input logic [7:0] prompt, input logic [23:0] fg,
                            input logic [23:0] bg);
    apb_write(REG_TEXT_COLUMNS, {23'd0, cols});
    apb_write(REG_TEXT_ROWS, {24'd0, rows});
    apb_write(REG_PROMPT_COLUMN, {24'd0, prompt});
    apb_write(REG_FOREGROUND_RGB, {8'd0, fg});
    apb_write(REG_BACKGROUND_RGB, {8'd0, bg});
  endtask

  // Random byte: mostly text, with control bytes, inits and raw values
  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)       send(CMD_INIT, 8'($urandom_range(0, 255)));
    else if (r < 14) send(CMD_PUT, CH_NEWLINE);
    else if (r < 22) send(CMD_PUT, CH_TAB);
    else if (r < 28) send(CMD_PUT, CH_RETURN);
    else if (r < 38) send(CMD_PUT, CH_BACKSPACE);
    else if (r < 50) send(CMD_PUT, 8'($urandom_range(0, 255)));
    else             send(CMD_PUT, 8'($urandom_range(33, 126)));
  endtask

  initial begin
    int phase;
    int n;
    logic [8:0] cols;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry: init ignores its byte, plain and extreme bytes, controls
    send(CMD_INIT, 8'hFF);
    send(CMD_PUT, 8'h41);
    send(CMD_PUT, 8'h00);
    send(CMD_PUT, 8'hFF);
    send(CMD_PUT, CH_TAB);
    send(CMD_PUT, CH_BACKSPACE);
    send(CMD_PUT, CH_RETURN);
    send(CMD_PUT, CH_BACKSPACE);
    send(CMD_PUT, CH_NEWLINE);
    send(CMD_PUT, 8'h7F);
    send(CMD_PUT, CH_TAB);
    settle();

    // Shrink the grid under the cursor, then wrap, scroll and guard the prompt
    set_screen(9'd3, 8'd2, 8'd1, 24'h123456, 24'hABCDEF);
    send(CMD_PUT, 8'h78);
    send(CMD_PUT, 8'h79);
    send(CMD_PUT, 8'h7A);
    send(CMD_PUT, CH_TAB);
    send(CMD_PUT, CH_BACKSPACE);
    send(CMD_PUT, 8'h71);
    send(CMD_PUT, CH_BACKSPACE);
    send(CMD_PUT, CH_NEWLINE);
    send(CMD_PUT, CH_RETURN);
    settle();

    // Zero geometry counts as a single cell: every draw and newline scrolls
    set_screen(9'd0, 8'd0, 8'd1, 24'hFFFFFF, 24'h000000);
    send(CMD_PUT, 8'h6B);
    send(CMD_PUT, CH_TAB);
    send(CMD_PUT, CH_NEWLINE);
    send(CMD_PUT, CH_BACKSPACE);
    settle();

    // Random phases, each under its own screen setting
    for (phase = 0; phase < 8; phase++) begin
      no_idle = (phase == 5);
      case (phase)
        0: set_screen(9'd256, 8'd128, 8'd0, 24'hFFFFFF, 24'h000000);
        1: set_screen(9'd511, 8'd255, 8'd255, 24'h000000, 24'hFFFFFF);
        2: set_screen(9'd1, 8'd1, 8'd0, 24'($urandom_range(0, 24'hFFFFFF)),
                      24'($urandom_range(0, 24'hFFFFFF)));
        3: set_screen(9'd0, 8'd0, 8'd0, 24'($urandom_range(0, 24'hFFFFFF)),
                      24'($urandom_range(0, 24'hFFFFFF)));
        default: begin
          cols = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(1, 12));
          set_screen(cols,
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(1, 6)),
                     8'($urandom_range(0, 4)),
                     24'($urandom_range(0, 24'hFFFFFF)),
                     24'($urandom_range(0, 24'hFFFFFF)));
        end
      endcase
      for (n = 0; n < 50; n++) send_random();
      settle();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
